[design/gga_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the GGA local time extractor.
// No dependencies; the parser, formatter and top level refer to this package by scoped names.
package gga_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_of_sentence;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
		logic [1:0] status;
	} out_item_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_BAD_HEADER = 2'd1;
	localparam status_t ST_NO_FIELD   = 2'd2;
	localparam status_t ST_BAD_DIGITS = 2'd3;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_HOURS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_MINUTES = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FIELD_INDEX    = 2'd2;

	localparam logic [4:0] OFFSET_HOURS_RST   = 5'd5;
	localparam logic [5:0] OFFSET_MINUTES_RST = 6'd30;
	localparam logic [3:0] FIELD_INDEX_RST    = 4'd1;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	localparam logic [2:0] HDR_LEN = 3'd5;

	// one unit of work handed from the parser to the formatter
	typedef struct packed {
		logic            is_err;
		status_t         status;
		logic [5:0][3:0] digits;
	} job_t;

	// expected header text "GPGGA"
	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		begin
			unique case (pos)
				3'd0: c = 8'h47;
				3'd1: c = 8'h50;
				3'd2: c = 8'h47;
				3'd3: c = 8'h47;
				3'd4: c = 8'h41;
				default: c = CHAR_NUL;
			endcase
			return c;
		end
	endfunction

endpackage

[design/gga_fifo.sv]
`timescale 1ns / 1ps
// Small register queue that holds parsed jobs between parser and formatter.
// Generic in width and depth; depends on nothing else.
module gga_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[design/gga_front.sv]
`timescale 1ns / 1ps
// Sentence parser: checks the header, counts commas and captures the time digits.
// Emits one job per finished sentence. Depends on gga_pkg.
module gga_front #(
	parameter int MAX_FIELD_INDEX = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  gga_pkg::in_item_t item,
	input  logic [3:0]        field_index,
	output logic              job_valid,
	output gga_pkg::job_t     job
);

	localparam int CW = $clog2(MAX_FIELD_INDEX + 1);
	localparam int LW = (CW > 4) ? CW : 4;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_COMMAS,
		PH_FIELD,
		PH_DONE
	} phase_t;

	phase_t          phase_q, phase_n, phase_e;
	logic [2:0]      hpos_q, hpos_n, hpos_e;
	logic [CW-1:0]   comma_q, comma_n, comma_e;
	logic [2:0]      dcnt_q, dcnt_n, dcnt_e;
	logic [5:0][3:0] digits_q;
	logic            digit_we;
	logic [LW-1:0]   idx_w;
	logic [CW-1:0]   limit;
	logic [CW:0]     comma_inc;
	logic [7:0]      b;
	logic            is_digit;

	// clamp the configured index to the supported maximum
	always_comb begin
		idx_w = LW'(field_index);
		if (idx_w > LW'(MAX_FIELD_INDEX)) begin
			limit = CW'(MAX_FIELD_INDEX);
		end else begin
			limit = CW'(idx_w);
		end
	end

	assign b         = item.in_byte;
	assign is_digit  = (b >= gga_pkg::CHAR_ZERO) && (b <= gga_pkg::CHAR_NINE);
	assign comma_inc = {1'b0, comma_e} + 1'b1;

	always_comb begin
		// a sentence start restarts parsing with this byte
		if (item.first_of_sentence) begin
			phase_e = PH_HEADER;
			hpos_e  = '0;
			comma_e = '0;
			dcnt_e  = '0;
		end else begin
			phase_e = phase_q;
			hpos_e  = hpos_q;
			comma_e = comma_q;
			dcnt_e  = dcnt_q;
		end
	end

	always_comb begin
		phase_n    = phase_e;
		hpos_n     = hpos_e;
		comma_n    = comma_e;
		dcnt_n     = dcnt_e;
		digit_we   = 1'b0;
		job_valid  = 1'b0;
		job.is_err = 1'b1;
		job.status = gga_pkg::ST_OK;
		job.digits = digits_q;
		if (accept) begin
			unique case (phase_e)
				PH_HEADER: begin
					if (hpos_e >= gga_pkg::HDR_LEN || b != gga_pkg::hdr_char(hpos_e)) begin
						job_valid  = 1'b1;
						job.status = gga_pkg::ST_BAD_HEADER;
						phase_n    = PH_DONE;
					end else begin
						hpos_n = hpos_e + 1'b1;
						if (hpos_n == gga_pkg::HDR_LEN) begin
							if (limit == '0) begin
								job_valid  = 1'b1;
								job.status = gga_pkg::ST_BAD_DIGITS;
								phase_n    = PH_DONE;
							end else begin
								phase_n = PH_COMMAS;
							end
						end
					end
				end
				PH_COMMAS: begin
					if (b == gga_pkg::CHAR_NUL) begin
						job_valid  = 1'b1;
						job.status = gga_pkg::ST_NO_FIELD;
						phase_n    = PH_DONE;
					end else if (b == gga_pkg::CHAR_COMMA) begin
						comma_n = CW'(comma_inc);
						if (comma_inc >= {1'b0, limit}) begin
							phase_n = PH_FIELD;
							dcnt_n  = '0;
						end
					end
				end
				PH_FIELD: begin
					if (b == gga_pkg::CHAR_NUL) begin
						job_valid  = 1'b1;
						job.status = gga_pkg::ST_NO_FIELD;
						phase_n    = PH_DONE;
					end else if (b == gga_pkg::CHAR_COMMA) begin
						job_valid = 1'b1;
						phase_n   = PH_DONE;
						if (dcnt_e < 3'd6) begin
							job.status = gga_pkg::ST_BAD_DIGITS;
						end else begin
							job.is_err = 1'b0;
						end
					end else if (dcnt_e < 3'd6) begin
						if (!is_digit) begin
							job_valid  = 1'b1;
							job.status = gga_pkg::ST_BAD_DIGITS;
							phase_n    = PH_DONE;
						end else begin
							digit_we = 1'b1;
							dcnt_n   = dcnt_e + 1'b1;
						end
					end
				end
				PH_DONE: begin
					// drop bytes until the next sentence start
				end
				default: begin
					phase_n = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hpos_q  <= '0;
			comma_q <= '0;
			dcnt_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			hpos_q  <= hpos_n;
			comma_q <= comma_n;
			dcnt_q  <= dcnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (digit_we) begin
			digits_q[dcnt_e] <= b[3:0];
		end
	end

endmodule

[design/gga_back.sv]
`timescale 1ns / 1ps
// Formatter: applies the local offset to a parsed time and streams hh:mm:ss,
// or a single error result. Holds the output register. Depends on gga_pkg.
module gga_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_present,
	input  gga_pkg::job_t      job,
	output logic               job_take,
	input  logic [4:0]         offset_hours,
	input  logic [5:0]         offset_minutes,
	input  logic               out_pop,
	output logic               out_valid,
	output gga_pkg::out_item_t result
);

	// tens and ones of a value below 64
	function automatic logic [7:0] split10(input logic [5:0] v);
		logic [3:0] t;
		logic [5:0] r;
		begin
			priority if (v >= 6'd60) t = 4'd6;
			else if (v >= 6'd50) t = 4'd5;
			else if (v >= 6'd40) t = 4'd4;
			else if (v >= 6'd30) t = 4'd3;
			else if (v >= 6'd20) t = 4'd2;
			else if (v >= 6'd10) t = 4'd1;
			else t = 4'd0;
			r = v - ({2'b00, t} << 3) - ({2'b00, t} << 1);
			return {t, r[3:0]};
		end
	endfunction

	gga_pkg::job_t      job_s1;
	logic               valid_s1;
	logic               run_valid_q;
	logic               run_err_q;
	gga_pkg::status_t   run_status_q;
	logic [7:0]         chars_q [8];
	logic [2:0]         idx_q;
	logic               out_valid_q;
	gga_pkg::out_item_t result_q;

	logic       emit_go;
	logic       run_done;
	logic       load_run;
	logic [6:0] uh;
	logic [6:0] um;
	logic [7:0] t;
	logic [1:0] carry;
	logic [5:0] mm;
	logic [7:0] hsum;
	logic [7:0] hmod;
	logic [7:0] hs;
	logic [7:0] ms;
	logic [7:0] chars_n [8];

	assign emit_go  = run_valid_q && (!out_valid_q || out_pop);
	assign run_done = emit_go && (run_err_q || idx_q == 3'd7);
	assign load_run = valid_s1 && (!run_valid_q || run_done);
	assign job_take = job_present && (!valid_s1 || load_run);

	// offset arithmetic on the staged job
	always_comb begin
		uh = ({3'b000, job_s1.digits[0]} << 3) + ({3'b000, job_s1.digits[0]} << 1)
			+ {3'b000, job_s1.digits[1]};
		um = ({3'b000, job_s1.digits[2]} << 3) + ({3'b000, job_s1.digits[2]} << 1)
			+ {3'b000, job_s1.digits[3]};
		t  = {1'b0, um} + {2'b00, offset_minutes};
		priority if (t >= 8'd120) carry = 2'd2;
		else if (t >= 8'd60) carry = 2'd1;
		else carry = 2'd0;
		unique case (carry)
			2'd2: mm = 6'(t - 8'd120);
			2'd1: mm = 6'(t - 8'd60);
			default: mm = 6'(t);
		endcase
		hsum = {1'b0, uh} + {3'b000, offset_hours} + {6'b000000, carry};
		priority if (hsum >= 8'd120) hmod = hsum - 8'd120;
		else if (hsum >= 8'd96) hmod = hsum - 8'd96;
		else if (hsum >= 8'd72) hmod = hsum - 8'd72;
		else if (hsum >= 8'd48) hmod = hsum - 8'd48;
		else if (hsum >= 8'd24) hmod = hsum - 8'd24;
		else hmod = hsum;
		hs = split10(hmod[5:0]);
		ms = split10(mm);
		chars_n[0] = gga_pkg::CHAR_ZERO | {4'h0, hs[7:4]};
		chars_n[1] = gga_pkg::CHAR_ZERO | {4'h0, hs[3:0]};
		chars_n[2] = gga_pkg::CHAR_COLON;
		chars_n[3] = gga_pkg::CHAR_ZERO | {4'h0, ms[7:4]};
		chars_n[4] = gga_pkg::CHAR_ZERO | {4'h0, ms[3:0]};
		chars_n[5] = gga_pkg::CHAR_COLON;
		chars_n[6] = gga_pkg::CHAR_ZERO | {4'h0, job_s1.digits[4]};
		chars_n[7] = gga_pkg::CHAR_ZERO | {4'h0, job_s1.digits[5]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			run_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_take) begin
				valid_s1 <= 1'b1;
			end else if (load_run) begin
				valid_s1 <= 1'b0;
			end
			if (load_run) begin
				run_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (run_done) begin
				run_valid_q <= 1'b0;
			end else if (emit_go) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_s1 <= job;
		end
		if (load_run) begin
			run_err_q    <= job_s1.is_err;
			run_status_q <= job_s1.status;
			chars_q      <= chars_n;
		end
		if (emit_go) begin
			result_q.out_char  <= run_err_q ? gga_pkg::CHAR_NUL : chars_q[idx_q];
			result_q.last_char <= run_err_q || (idx_q == 3'd7);
			result_q.status    <= run_err_q ? run_status_q : gga_pkg::ST_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

[design/gga_utc_to_local_time.sv]
`timescale 1ns / 1ps
// Top level of the GGA local time extractor: config registers, parser, job queue
// and formatter. Depends on gga_pkg, gga_front, gga_fifo and gga_back.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------------
//   input    | in        | push / full          | item   (in_byte, first_of_sentence)
//   result   | out       | pop / empty          | result (out_char, last_char, status)
//   config   | in        | cfg_wr_en            | cfg_index, cfg_wdata
//
// The parser takes one byte per cycle while full is low. A sentence that ends in error
// gives one result; a good time field gives eight formatter results, one per cycle
// while pop keeps up. Finished jobs wait in a JOB_DEPTH entry queue; full rises only
// while that queue is full, i.e. while the formatter is still streaming earlier jobs
// or pop is low. Jobs pass the queue, staging, run and output registers.
// Reset clears all control state; no clearing pass is needed.
module gga_utc_to_local_time #(
	parameter int MAX_FIELD_INDEX = 15,
	parameter int JOB_DEPTH       = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  gga_pkg::in_item_t                   item,
	output logic                                empty,
	input  logic                                pop,
	output gga_pkg::out_item_t                  result,
	input  logic                                cfg_wr_en,
	input  logic [gga_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gga_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int JOB_W = $bits(gga_pkg::job_t);

	logic [4:0]    offset_hours_q;
	logic [5:0]    offset_minutes_q;
	logic [3:0]    field_index_q;
	logic          accept;
	logic          job_valid;
	gga_pkg::job_t job_in;
	gga_pkg::job_t job_out;
	logic          fifo_full;
	logic          fifo_empty;
	logic          job_take;
	logic          out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_hours_q   <= gga_pkg::OFFSET_HOURS_RST;
			offset_minutes_q <= gga_pkg::OFFSET_MINUTES_RST;
			field_index_q    <= gga_pkg::FIELD_INDEX_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				gga_pkg::REG_OFFSET_HOURS:   offset_hours_q   <= cfg_wdata[4:0];
				gga_pkg::REG_OFFSET_MINUTES: offset_minutes_q <= cfg_wdata[5:0];
				gga_pkg::REG_FIELD_INDEX:    field_index_q    <= cfg_wdata[3:0];
				default: begin
					// unused index: drop the write
				end
			endcase
		end
	end

	assign full   = fifo_full;
	assign accept = push && !fifo_full;
	assign empty  = !out_valid;

	gga_front #(
		.MAX_FIELD_INDEX(MAX_FIELD_INDEX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.field_index(field_index_q),
		.job_valid  (job_valid),
		.job        (job_in)
	);

	gga_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (job_valid),
		.wdata (job_in),
		.rd_en (job_take),
		.rdata (job_out),
		.full  (fifo_full),
		.empty (fifo_empty)
	);

	gga_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_present   (!fifo_empty),
		.job           (job_out),
		.job_take      (job_take),
		.offset_hours  (offset_hours_q),
		.offset_minutes(offset_minutes_q),
		.out_pop       (pop && out_valid),
		.out_valid     (out_valid),
		.result        (result)
	);

	// a job is only produced for an accepted byte, so it always finds room
	a_job_fits: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> !fifo_full && accept)
		else $error("job produced while queue full or without an accepted byte");

	// error results are single, zero-character transactions
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != gga_pkg::ST_OK) |->
			(result.last_char && result.out_char == gga_pkg::CHAR_NUL))
		else $error("malformed error result");

	// the final character of a good time is a seconds digit
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == gga_pkg::ST_OK && result.last_char) |->
			(result.out_char >= gga_pkg::CHAR_ZERO && result.out_char <= gga_pkg::CHAR_NINE))
		else $error("last time character is not a digit");

	// the formatter only pulls a job that the queue holds
	a_take_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> !fifo_empty)
		else $error("formatter took a job from an empty queue");

endmodule
